@@ rtl/core/u8rs_pkg.sv @@
// Shared types, constants and functions of the reverse UTF-8 segmenter.
package u8rs_pkg;

  localparam int unsigned RunWidth   = 3;
  localparam int unsigned UnitWidth  = 8;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned MDataWidth = 40;

  localparam logic [UnitWidth-1:0]  REPL_UNIT0 = 8'hEF;
  localparam logic [UnitWidth-1:0]  REPL_UNIT1 = 8'hBF;
  localparam logic [UnitWidth-1:0]  REPL_UNIT2 = 8'hBD;
  localparam logic [CountWidth-1:0] REPL_COUNT = 3'd3;
  localparam logic [RunWidth-1:0]   RUN_MAX    = 3'd7;

  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_ONE  = 2'd1;
  localparam logic [1:0] EMIT_TWO  = 2'd2;

  typedef struct packed {
    logic [UnitWidth-1:0]  unit0;
    logic [UnitWidth-1:0]  unit1;
    logic [UnitWidth-1:0]  unit2;
    logic [UnitWidth-1:0]  unit3;
    logic [CountWidth-1:0] unit_count;
    logic                  replaced;
    logic                  last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]          emit;
    result_t             first;
    result_t             second;
    logic                shift_trail;
    logic [RunWidth-1:0] run_next;
  } decode_t;

  function automatic result_t repl_result(input logic last);
    result_t r;
    r.unit0       = REPL_UNIT0;
    r.unit1       = REPL_UNIT1;
    r.unit2       = REPL_UNIT2;
    r.unit3       = '0;
    r.unit_count  = REPL_COUNT;
    r.replaced    = 1'b1;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic logic [MDataWidth-1:0] pack_data(input result_t r);
    return {5'b0, r.unit_count, r.unit3, r.unit2, r.unit1, r.unit0};
  endfunction

endpackage

@@ rtl/core/u8rs_decode.sv @@
// Combinational decode of one byte against the pending trail count and trail bytes.
module u8rs_decode (
  input  logic [7:0]                     code_unit,
  input  logic                           text_start,
  input  logic [u8rs_pkg::RunWidth-1:0]  trail_run,
  input  logic [7:0]                     trail0,
  input  logic [7:0]                     trail1,
  input  logic [7:0]                     trail2,
  output u8rs_pkg::decode_t              dec
);

  logic       is_trail;
  logic       lead_bad;
  logic [1:0] need;
  u8rs_pkg::result_t char_res;

  assign is_trail = (code_unit[7:6] == 2'b10);

  always_comb begin
    lead_bad = 1'b0;
    need     = 2'd0;
    if (code_unit < 8'h80) begin
      need = 2'd0;
    end else if (code_unit < 8'hC2) begin
      lead_bad = 1'b1;
    end else if (code_unit < 8'hE0) begin
      need = 2'd1;
    end else if (code_unit < 8'hF0) begin
      need = 2'd2;
    end else if (code_unit <= 8'hF4) begin
      need = 2'd3;
    end else begin
      lead_bad = 1'b1;
    end
  end

  always_comb begin
    char_res.unit0       = code_unit;
    char_res.unit1       = (need >= 2'd1) ? trail0 : 8'h00;
    char_res.unit2       = (need >= 2'd2) ? trail1 : 8'h00;
    char_res.unit3       = (need == 2'd3) ? trail2 : 8'h00;
    char_res.unit_count  = {1'b0, need} + 3'd1;
    char_res.replaced    = 1'b0;
    char_res.last_of_run = 1'b1;
  end

  always_comb begin
    dec.emit        = u8rs_pkg::EMIT_NONE;
    dec.first       = u8rs_pkg::repl_result(1'b1);
    dec.second      = char_res;
    dec.shift_trail = is_trail;
    dec.run_next    = 3'd0;
    if (is_trail) begin
      if (text_start) begin
        dec.emit = u8rs_pkg::EMIT_ONE;
      end else begin
        dec.run_next = (trail_run == u8rs_pkg::RUN_MAX) ? trail_run : trail_run + 3'd1;
      end
    end else if (lead_bad || ({1'b0, need} > trail_run)) begin
      dec.emit = u8rs_pkg::EMIT_ONE;
    end else if ({1'b0, need} == trail_run) begin
      dec.emit  = u8rs_pkg::EMIT_ONE;
      dec.first = char_res;
    end else begin
      dec.emit  = u8rs_pkg::EMIT_TWO;
      dec.first = u8rs_pkg::repl_result(1'b0);
    end
  end

endmodule

@@ rtl/core/utf8_reverse_segmenter_core.sv @@
// Top level of the reverse UTF-8 segmenter: stream ports, state and result registers.
//
// Bytes of a UTF-8 text enter last byte first, one per transaction, with s_tlast marking the
// first byte of the text. Whole code points leave back to front, each with its bytes in forward
// order; malformed runs leave as U+FFFD with m_tuser set. The block takes one byte every cycle
// while the output is free and the holding register is empty. A lead byte that closes more
// trail bytes than it needs yields two transactions, and then s_tready stays low while the
// second one waits in the holding register behind the output register, until the first is taken.
// The first result of a byte appears on the output in the cycle after the byte is accepted;
// the second one follows in the cycle after the first one is taken.
module utf8_reverse_segmenter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_unit
  input  logic        s_tlast,   // text_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] unit0, [15:8] unit1, [23:16] unit2, [31:24] unit3,
                                 // [34:32] unit_count, [39:35] zero
  output logic [0:0]  m_tuser,   // [0] replaced
  output logic        m_tlast    // last_of_run
);

  logic [u8rs_pkg::RunWidth-1:0] trail_run;
  logic [7:0]                    recent_trails [3];
  u8rs_pkg::decode_t             dec;
  u8rs_pkg::result_t             out_res;
  u8rs_pkg::result_t             hold_res;
  logic                          hold_valid;
  logic                          accept;

  u8rs_decode u_decode (
    .code_unit  (s_tdata),
    .text_start (s_tlast),
    .trail_run  (trail_run),
    .trail0     (recent_trails[0]),
    .trail1     (recent_trails[1]),
    .trail2     (recent_trails[2]),
    .dec        (dec)
  );

  assign s_tready = !hold_valid && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trail_run <= '0;
    end else if (accept) begin
      trail_run <= dec.run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec.shift_trail) begin
      recent_trails[2] <= recent_trails[1];
      recent_trails[1] <= recent_trails[0];
      recent_trails[0] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      hold_valid <= 1'b0;
    end else if (accept) begin
      m_tvalid   <= (dec.emit != u8rs_pkg::EMIT_NONE);
      hold_valid <= (dec.emit == u8rs_pkg::EMIT_TWO);
    end else if (m_tvalid && m_tready) begin
      m_tvalid   <= hold_valid;
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res  <= dec.first;
      hold_res <= dec.second;
    end else if (m_tvalid && m_tready && hold_valid) begin
      out_res <= hold_res;
    end
  end

  assign m_tdata    = u8rs_pkg::pack_data(out_res);
  assign m_tuser[0] = out_res.replaced;
  assign m_tlast    = out_res.last_of_run;

  a_hold_behind_output: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> m_tvalid)
    else $error("holding register is full while the output register is empty");

  a_first_of_pair_waits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> hold_valid)
    else $error("first result of a pair has no second result behind it");

  a_hold_is_char: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (!hold_res.replaced && hold_res.last_of_run))
    else $error("held second result is not a final valid code point");

endmodule

@@ tb/sv/utf8_reverse_segmenter_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the reverse UTF-8 segmenter core.
module utf8_reverse_segmenter_core_tb;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 470;
  localparam int DIR_ROWS    = 22;

  typedef struct {
    logic [7:0]        cu;
    logic              ts;
    int                reps;
    bit                typed;
    int                n;
    u8rs_pkg::result_t r0;
    u8rs_pkg::result_t r1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  u8rs_pkg::result_t pending_cps[$];
  logic [2:0] pend_trails = '0;
  logic [7:0] trail_hist[3] = '{8'h00, 8'h00, 8'h00};
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         bytes_sent = 0;
  int         cps_seen = 0;
  int         repl_seen = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  dir_row_t   dir_rows[DIR_ROWS];

  utf8_reverse_segmenter_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic u8rs_pkg::result_t fffd_result(input logic last);
    u8rs_pkg::result_t r;
    r = '0;
    r.unit0       = 8'hEF;
    r.unit1       = 8'hBF;
    r.unit2       = 8'hBD;
    r.unit_count  = 3'd3;
    r.replaced    = 1'b1;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic u8rs_pkg::result_t single_unit(input logic [7:0] b);
    u8rs_pkg::result_t r;
    r = '0;
    r.unit0       = b;
    r.unit_count  = 3'd1;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic u8rs_pkg::result_t code_point(input logic [7:0] lead, input int n);
    u8rs_pkg::result_t r;
    r = '0;
    r.unit0       = lead;
    r.unit1       = (n >= 1) ? trail_hist[0] : 8'h00;
    r.unit2       = (n >= 2) ? trail_hist[1] : 8'h00;
    r.unit3       = (n >= 3) ? trail_hist[2] : 8'h00;
    r.unit_count  = 3'(n + 1);
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic int trails_for_lead(input logic [7:0] b);
    if (b < 8'h80) return 0;
    if (b < 8'hC2) return -1;
    if (b < 8'hE0) return 1;
    if (b < 8'hF0) return 2;
    if (b <= 8'hF4) return 3;
    return -1;
  endfunction

  task automatic decode_backward(input logic [7:0] cu, input logic ts, output int n,
                                 output u8rs_pkg::result_t r0,
                                 output u8rs_pkg::result_t r1);
    int need;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (cu[7:6] == 2'b10) begin
      trail_hist[2] = trail_hist[1];
      trail_hist[1] = trail_hist[0];
      trail_hist[0] = cu;
      if (pend_trails != u8rs_pkg::RUN_MAX) pend_trails = pend_trails + 3'd1;
      if (ts) begin
        pend_trails = '0;
        n  = 1;
        r0 = fffd_result(1'b1);
      end
    end else begin
      need = trails_for_lead(cu);
      if (need < 0 || need > int'(pend_trails)) begin
        n  = 1;
        r0 = fffd_result(1'b1);
      end else if (need == int'(pend_trails)) begin
        n  = 1;
        r0 = code_point(cu, need);
      end else begin
        n  = 2;
        r0 = fffd_result(1'b0);
        r1 = code_point(cu, need);
      end
      pend_trails = '0;
    end
  endtask

  task automatic send_unit(input logic [7:0] cu, input logic ts, input bit typed,
                           input int typed_n, input u8rs_pkg::result_t t0,
                           input u8rs_pkg::result_t t1);
    int                n;
    u8rs_pkg::result_t r0;
    u8rs_pkg::result_t r1;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cu;
    s_tlast  <= ts;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    decode_backward(cu, ts, n, r0, r1);
    if (typed) begin
      n  = typed_n;
      r0 = t0;
      r1 = t1;
    end
    if (n >= 1) pending_cps.push_back(r0);
    if (n >= 2) pending_cps.push_back(r1);
  endtask

  task automatic feed_text();
    logic [7:0] fwd[$];
    int         n_cp;
    int         len;
    int         k;
    int         pos;
    logic [7:0] lead;
    bit         with_start;
    n_cp = $urandom_range(1, 6);
    for (int c = 0; c < n_cp; c++) begin
      len = $urandom_range(1, 4);
      case (len)
        1: lead = 8'($urandom_range(8'h00, 8'h7F));
        2: lead = 8'($urandom_range(8'hC2, 8'hDF));
        3: lead = 8'($urandom_range(8'hE0, 8'hEF));
        default: lead = 8'($urandom_range(8'hF0, 8'hF4));
      endcase
      fwd.push_back(lead);
      for (k = 1; k < len; k++) fwd.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
    if ($urandom_range(99) < 25) begin
      pos = $urandom_range(0, fwd.size() - 1);
      case ($urandom_range(0, 3))
        0: fwd[pos] = 8'($urandom);
        1: if (fwd.size() > 1) fwd.delete(pos);
        2: fwd.insert(pos, 8'h80 | 8'($urandom_range(0, 63)));
        default: begin
          for (k = $urandom_range(4, 9); k > 0; k--)
            fwd.insert(pos, 8'h80 | 8'($urandom_range(0, 63)));
        end
      endcase
    end
    with_start = $urandom_range(0, 1);
    for (k = fwd.size() - 1; k >= 0; k--)
      send_unit(fwd[k], with_start && (k == 0), 1'b0, 0, '0, '0);
  endtask

  task automatic run_phase(input int idle, input int stall);
    int target;
    idle_pct  = idle;
    stall_pct = stall;
    target    = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 12)
        send_unit(8'($urandom), 1'($urandom), 1'b0, 0, '0, '0);
      else
        feed_text();
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    u8rs_pkg::result_t act;
    u8rs_pkg::result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      act.unit0       = m_tdata[7:0];
      act.unit1       = m_tdata[15:8];
      act.unit2       = m_tdata[23:16];
      act.unit3       = m_tdata[31:24];
      act.unit_count  = m_tdata[34:32];
      act.replaced    = m_tuser[0];
      act.last_of_run = m_tlast;
      cps_seen++;
      if (act.replaced) repl_seen++;
      if (pending_cps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected code point: expected none, %s %h %h %h %h n=%0d r=%b l=%b",
                 $time, "actual", act.unit0, act.unit1, act.unit2, act.unit3,
                 act.unit_count, act.replaced, act.last_of_run);
      end else begin
        exp_r = pending_cps.pop_front();
        if (act !== exp_r) begin
          mismatches++;
          $display({"%0t: mismatch: expected %h %h %h %h n=%0d r=%b l=%b, ",
                    "actual %h %h %h %h n=%0d r=%b l=%b"},
                   $time, exp_r.unit0, exp_r.unit1, exp_r.unit2, exp_r.unit3,
                   exp_r.unit_count, exp_r.replaced, exp_r.last_of_run,
                   act.unit0, act.unit1, act.unit2, act.unit3, act.unit_count,
                   act.replaced, act.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d code points outstanding", $time, pending_cps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      '{8'h00, 1'b0, 1, 1'b1, 1, single_unit(8'h00), '0},
      '{8'h7F, 1'b0, 1, 1'b1, 1, single_unit(8'h7F), '0},
      '{8'hFF, 1'b0, 1, 1'b1, 1, fffd_result(1'b1), '0},
      '{8'hC0, 1'b0, 1, 1'b1, 1, fffd_result(1'b1), '0},
      '{8'hF5, 1'b0, 1, 1'b1, 1, fffd_result(1'b1), '0},
      '{8'h80, 1'b0, 1, 1'b1, 0, '0, '0},
      '{8'hC2, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'hBD, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'hBF, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'hEF, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'h80, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'hE0, 1'b0, 1, 1'b1, 1, fffd_result(1'b1), '0},
      '{8'h80, 1'b0, 2, 1'b0, 0, '0, '0},
      '{8'h41, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'hBF, 1'b1, 1, 1'b1, 1, fffd_result(1'b1), '0},
      '{8'h80, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'h80, 1'b1, 1, 1'b0, 0, '0, '0},
      '{8'hDF, 1'b1, 1, 1'b0, 0, '0, '0},
      '{8'h80, 1'b0, 7, 1'b0, 0, '0, '0},
      '{8'hF4, 1'b0, 1, 1'b0, 0, '0, '0},
      '{8'h80, 1'b0, 3, 1'b0, 0, '0, '0},
      '{8'hF0, 1'b0, 1, 1'b0, 0, '0, '0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int j = 0; j < dir_rows[i].reps; j++)
        send_unit(dir_rows[i].cu, dir_rows[i].ts, dir_rows[i].typed, dir_rows[i].n,
                  dir_rows[i].r0, dir_rows[i].r1);
    end
    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(18, 18);
    s_tvalid <= 1'b0;
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes backward and checked %0d code points, %0d of them replacements,",
             bytes_sent, cps_seen, repl_seen);
    $display("under free-running, idle-sender, stalled-receiver and mixed pacing.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
